/* hw/rtl/seb_pkg.sv */
// Shared types, constants and saturating helpers for the shooting eigenvalue solver.
`timescale 1ns / 1ps
package seb_pkg;

	typedef logic signed [39:0] q40_t;
	typedef logic signed [43:0] q44_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_K2, ST_STEP, ST_SHOT_END, ST_CHECK_BRACKET, ST_IT_BEGIN,
		ST_SEC_MUL, ST_SEC_DIV, ST_CHOOSE, ST_IT_UPD, ST_IT_CHK, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_FA, PH_FB, PH_ITER} phase_t;

	typedef enum logic [1:0] {SH_24, SH_25, SH_42} shift_t;

	typedef enum logic [3:0] {
		OP_K1D, OP_Y2, OP_D2, OP_K2D, OP_Y3, OP_D3, OP_K3D,
		OP_Y4, OP_D4, OP_K4D, OP_PY, OP_Y, OP_PD, OP_DY
	} op_t;

	typedef struct packed {
		logic        start;
		logic [41:0] a;
		logic [41:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [79:0] num;
		logic [40:0] den;
	} div_req_t;

	localparam logic [1:0] STAT_CONV   = 2'd0;
	localparam logic [1:0] STAT_NOSIGN = 2'd1;
	localparam logic [1:0] STAT_LIMIT  = 2'd2;

	localparam logic [1:0] CFG_SHOT_STEPS = 2'd0;
	localparam logic [1:0] CFG_STEP_SIZE  = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

	localparam q40_t MAX40   = 40'sh7F_FFFF_FFFF;
	localparam q40_t MIN40   = 40'sh80_0000_0000;
	localparam q40_t ONE_Q24 = 40'sd16777216;
	// ceil(2^42 / 3): floor(m*RECIP3 >> 42) == floor(m/3) for m < 2^41
	localparam logic [41:0] RECIP3 = 42'd1466015503702;

	function automatic q40_t sat40(input q44_t v);
		q40_t r;
		if (v > 44'sd549755813887) r = MAX40;
		else if (v < -44'sd549755813888) r = MIN40;
		else r = v[39:0];
		return r;
	endfunction

	function automatic logic [43:0] magx(input q44_t v);
		logic [43:0] r;
		r = v[43] ? 44'(-v) : 44'(v);
		return r;
	endfunction

	function automatic q40_t negsat(input q40_t v);
		q40_t r;
		r = (v == MIN40) ? MAX40 : 40'(-v);
		return r;
	endfunction

endpackage

/* hw/rtl/shooting_eigenvalue_brent_rk4_unit.sv */
// Top level: shooting-method eigenvalue solver with RK4 shots and Brent root search.
// Each RK4 step makes fourteen passes of the shared multiplier, and a shot runs N steps
// (N = min(shot_steps, MAX_STEPS)); a request runs 2 + I shots (I Brent iterations, at
// most MAX_ITER), plus one secant divide in each iteration that takes the secant path.
// Throughput: one request at a time; s_tready is high only while idle.
// Reset: arst_n clears the sequencer and output valid and loads the register defaults.
`timescale 1ns / 1ps
module shooting_eigenvalue_brent_rk4_unit #(
	parameter int MAX_ITER  = 200,
	parameter int MAX_STEPS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] bracket_low, [63:32] bracket_high
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] eigen_wavenumber, [33:32] solve_status, rest 0
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data
);
	localparam logic [13:0] MaxSteps = 14'(MAX_STEPS);
	localparam logic [7:0]  LastIter = 8'(MAX_ITER - 1);

	seb_pkg::state_t state_q, state_d;
	seb_pkg::phase_t phase_q;
	seb_pkg::op_t    op_q;

	// configuration
	logic [12:0] shot_steps_q;
	logic [24:0] step_size_q, tolerance_q;

	// shot datapath
	seb_pkg::q40_t k_q, k22_q, y_q, dy_q, y2_q, d2_q, y3_q, d3_q, y4_q, d4_q;
	seb_pkg::q40_t k1d_q, k2d_q, k3d_q, k4d_q, p_q;
	logic [12:0]   step_q, n_eff;

	// root search
	seb_pkg::q40_t a_q, b_q, c_q, d_q, fa_q, fb_q, fc_q, sv_q;
	logic          mf_q;
	logic [7:0]    it_q;
	logic [1:0]    res_st_q;
	logic [31:0]   res_k_q;

	logic          mul_pend_q, m_valid_q;
	logic [39:0]   m_data_q;

	seb_pkg::mul_req_t mul_req;
	seb_pkg::div_req_t div_req;
	logic              mul_done, div_done;
	logic [83:0]       mul_prod;
	logic [41:0]       div_quo;

	logic [41:0]     mul_a, mul_b, h42;
	seb_pkg::shift_t mul_sh;
	logic            mul_neg, mul_state, out_free, in_acc;
	logic [59:0]     res;
	seb_pkg::q40_t   mul_r, sy, sd, mid, qv, sv_sec, sv_new, na, nb, nfa, nfb;
	seb_pkg::q44_t   dba, dfa, dfc, s3;
	logic [43:0]     t44;
	logic            sec_ok, between, cn, conv, swap;

	seb_mul u_mul (.clk, .arst_n, .req(mul_req), .done(mul_done), .prod(mul_prod));
	seb_div u_div (.clk, .arst_n, .req(div_req), .done(div_done), .quo(div_quo));

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;

	// clamp steps per shot
	assign n_eff = ({1'b0, shot_steps_q} > MaxSteps) ? MaxSteps[12:0] : shot_steps_q;
	assign h42   = {17'b0, step_size_q};
	assign t44   = {19'b0, tolerance_q};

	// weighted RK4 slopes
	assign sy = seb_pkg::sat40(44'(dy_q) + 44'(2) * (44'(d2_q) + 44'(d3_q)) + 44'(d4_q));
	assign sd = seb_pkg::sat40(44'(k1d_q) + 44'(2) * (44'(k2d_q) + 44'(k3d_q)) + 44'(k4d_q));

	// select operands of the shared multiplier
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_sh  = seb_pkg::SH_24;
		mul_neg = 1'b0;
		case (state_q)
			seb_pkg::ST_K2: begin
				mul_a = 42'(seb_pkg::magx(44'(k_q)));
				mul_b = mul_a;
			end
			seb_pkg::ST_SEC_MUL: begin
				mul_a = 42'(seb_pkg::magx(44'(fb_q)));
				mul_b = 42'(seb_pkg::magx(dba));
			end
			seb_pkg::ST_STEP: begin
				case (op_q)
					seb_pkg::OP_K1D, seb_pkg::OP_K2D, seb_pkg::OP_K3D, seb_pkg::OP_K4D: begin
						mul_a = 42'(seb_pkg::magx(44'(k22_q)));
						case (op_q)
							seb_pkg::OP_K1D: begin
								mul_b = 42'(seb_pkg::magx(44'(y_q)));
								mul_neg = k22_q[39] ^ y_q[39];
							end
							seb_pkg::OP_K2D: begin
								mul_b = 42'(seb_pkg::magx(44'(y2_q)));
								mul_neg = k22_q[39] ^ y2_q[39];
							end
							seb_pkg::OP_K3D: begin
								mul_b = 42'(seb_pkg::magx(44'(y3_q)));
								mul_neg = k22_q[39] ^ y3_q[39];
							end
							default: begin
								mul_b = 42'(seb_pkg::magx(44'(y4_q)));
								mul_neg = k22_q[39] ^ y4_q[39];
							end
						endcase
					end
					seb_pkg::OP_Y, seb_pkg::OP_DY: begin
						// divide by six: halve, then multiply by the reciprocal of three
						mul_a   = {2'b0, 40'(seb_pkg::magx(44'(p_q)))} >> 1;
						mul_b   = seb_pkg::RECIP3;
						mul_sh  = seb_pkg::SH_42;
						mul_neg = p_q[39];
					end
					default: begin
						mul_b = h42;
						case (op_q)
							seb_pkg::OP_Y2: begin
								mul_a = 42'(seb_pkg::magx(44'(dy_q)));
								mul_sh = seb_pkg::SH_25; mul_neg = dy_q[39];
							end
							seb_pkg::OP_D2: begin
								mul_a = 42'(seb_pkg::magx(44'(k1d_q)));
								mul_sh = seb_pkg::SH_25; mul_neg = k1d_q[39];
							end
							seb_pkg::OP_Y3: begin
								mul_a = 42'(seb_pkg::magx(44'(d2_q)));
								mul_sh = seb_pkg::SH_25; mul_neg = d2_q[39];
							end
							seb_pkg::OP_D3: begin
								mul_a = 42'(seb_pkg::magx(44'(k2d_q)));
								mul_sh = seb_pkg::SH_25; mul_neg = k2d_q[39];
							end
							seb_pkg::OP_Y4: begin
								mul_a = 42'(seb_pkg::magx(44'(d3_q))); mul_neg = d3_q[39];
							end
							seb_pkg::OP_D4: begin
								mul_a = 42'(seb_pkg::magx(44'(k3d_q))); mul_neg = k3d_q[39];
							end
							seb_pkg::OP_PY: begin
								mul_a = 42'(seb_pkg::magx(44'(sy))); mul_neg = sy[39];
							end
							default: begin
								mul_a = 42'(seb_pkg::magx(44'(sd))); mul_neg = sd[39];
							end
						endcase
					end
				endcase
			end
			default: ;
		endcase
	end

	// scale, sign and saturate the product
	always_comb begin
		case (mul_sh)
			seb_pkg::SH_25: res = {1'b0, mul_prod[83:25]};
			seb_pkg::SH_42: res = {18'b0, mul_prod[83:42]};
			default:        res = mul_prod[83:24];
		endcase
		if (mul_neg)
			mul_r = (res > 60'd549755813888) ? seb_pkg::MIN40 : 40'(-res[39:0]);
		else
			mul_r = (res > 60'd549755813887) ? seb_pkg::MAX40 : res[39:0];
	end

	// Brent arithmetic
	always_comb begin
		logic [43:0] q_s, mb;
		seb_pkg::q44_t s, sv44, q44, b44;
		dba  = 44'(b_q) - 44'(a_q);
		dfa  = 44'(fb_q) - 44'(fa_q);
		dfc  = 44'(fb_q) - 44'(fc_q);
		sec_ok = (seb_pkg::magx(dfa) > t44) && (seb_pkg::magx(dfc) > t44);
		s    = 44'(a_q) + 44'(b_q);
		mid  = 40'((s + 44'(s[43])) >>> 1);
		s3   = 44'(3) * 44'(a_q) + 44'(b_q);
		qv   = 40'((s3 + (s3[43] ? 44'sd3 : 44'sd0)) >>> 2);
		q_s  = (fb_q[39] ^ dba[43] ^ dfa[43]) ? 44'(-{2'b0, div_quo}) : {2'b0, div_quo};
		sv_sec = seb_pkg::sat40(44'(b_q) - $signed(q_s));
		sv44 = 44'(sv_q);
		q44  = 44'(qv);
		b44  = 44'(b_q);
		between = (sv44 > q44 && sv44 < b44) || (sv44 < q44 && sv44 > b44);
		mb   = seb_pkg::magx(sv44 - b44);
		cn   = !between
			|| ( mf_q && {mb, 1'b0} >= {1'b0, seb_pkg::magx(b44 - 44'(c_q))})
			|| (!mf_q && {mb, 1'b0} >= {1'b0, seb_pkg::magx(44'(c_q) - 44'(d_q))})
			|| ( mf_q && seb_pkg::magx(b44 - 44'(c_q)) < t44)
			|| (!mf_q && seb_pkg::magx(44'(c_q) - 44'(d_q)) < t44);
		sv_new = cn ? mid : sv_q;
		// bracket update with the new shot value held in y
		if ((fa_q[39] && !y_q[39] && y_q != '0) || (!fa_q[39] && fa_q != '0 && y_q[39])) begin
			na = a_q; nfa = fa_q; nb = sv_q; nfb = y_q;
		end else begin
			na = sv_q; nfa = y_q; nb = b_q; nfb = fb_q;
		end
		swap = seb_pkg::magx(44'(nfa)) < seb_pkg::magx(44'(nfb));
		conv = (seb_pkg::magx(44'(fb_q)) < t44) || (seb_pkg::magx(dba) < t44);
	end

	assign mul_state = (state_q == seb_pkg::ST_K2) || (state_q == seb_pkg::ST_STEP)
		|| (state_q == seb_pkg::ST_SEC_MUL);

	// handshakes and unit requests
	always_comb begin
		s_tready      = (state_q == seb_pkg::ST_IDLE);
		mul_req.start = mul_state && !mul_pend_q;
		mul_req.a     = mul_a;
		mul_req.b     = mul_b;
		div_req.start = (state_q == seb_pkg::ST_SEC_MUL) && mul_done;
		div_req.num   = mul_prod[79:0];
		div_req.den   = 41'(seb_pkg::magx(dfa));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			seb_pkg::ST_IDLE:
				if (s_tvalid) state_d = seb_pkg::ST_K2;
			seb_pkg::ST_K2:
				if (mul_done) state_d = (n_eff == '0) ? seb_pkg::ST_SHOT_END : seb_pkg::ST_STEP;
			seb_pkg::ST_STEP:
				if (mul_done && op_q == seb_pkg::OP_DY && step_q + 13'd1 == n_eff)
					state_d = seb_pkg::ST_SHOT_END;
			seb_pkg::ST_SHOT_END: begin
				case (phase_q)
					seb_pkg::PH_FA: state_d = seb_pkg::ST_K2;
					seb_pkg::PH_FB: state_d = seb_pkg::ST_CHECK_BRACKET;
					default:        state_d = seb_pkg::ST_IT_UPD;
				endcase
			end
			seb_pkg::ST_CHECK_BRACKET:
				state_d = ((!fa_q[39] && fa_q != '0 && !fb_q[39] && fb_q != '0)
					|| (fa_q[39] && fb_q[39])) ? seb_pkg::ST_OUT : seb_pkg::ST_IT_BEGIN;
			seb_pkg::ST_IT_BEGIN:
				state_d = sec_ok ? seb_pkg::ST_SEC_MUL : seb_pkg::ST_CHOOSE;
			seb_pkg::ST_SEC_MUL:
				if (mul_done) state_d = seb_pkg::ST_SEC_DIV;
			seb_pkg::ST_SEC_DIV:
				if (div_done) state_d = seb_pkg::ST_CHOOSE;
			seb_pkg::ST_CHOOSE:
				state_d = seb_pkg::ST_K2;
			seb_pkg::ST_IT_UPD:
				state_d = seb_pkg::ST_IT_CHK;
			seb_pkg::ST_IT_CHK:
				state_d = (conv || it_q == LastIter) ? seb_pkg::ST_OUT : seb_pkg::ST_IT_BEGIN;
			seb_pkg::ST_OUT:
				if (out_free) state_d = seb_pkg::ST_IDLE;
			default:
				state_d = seb_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= seb_pkg::ST_IDLE;
			phase_q      <= seb_pkg::PH_FA;
			op_q         <= seb_pkg::OP_K1D;
			mul_pend_q   <= 1'b0;
			m_valid_q    <= 1'b0;
			shot_steps_q <= 13'd1000;
			step_size_q  <= 25'd16777;
			tolerance_q  <= 25'd17;
		end else begin
			state_q <= state_d;
			if (mul_req.start) mul_pend_q <= 1'b1;
			else if (mul_done) mul_pend_q <= 1'b0;
			if (state_q == seb_pkg::ST_K2) op_q <= seb_pkg::OP_K1D;
			else if (state_q == seb_pkg::ST_STEP && mul_done)
				op_q <= (op_q == seb_pkg::OP_DY) ? seb_pkg::OP_K1D : seb_pkg::op_t'(op_q + 4'd1);
			if (in_acc) phase_q <= seb_pkg::PH_FA;
			else if (state_q == seb_pkg::ST_SHOT_END && phase_q == seb_pkg::PH_FA)
				phase_q <= seb_pkg::PH_FB;
			else if (state_q == seb_pkg::ST_CHOOSE) phase_q <= seb_pkg::PH_ITER;
			// hold a finished beat until taken; load the next one on the way out
			if (state_q == seb_pkg::ST_OUT && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					seb_pkg::CFG_SHOT_STEPS: shot_steps_q <= cfg_data[12:0];
					seb_pkg::CFG_STEP_SIZE:  step_size_q  <= cfg_data;
					seb_pkg::CFG_TOLERANCE:  tolerance_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			seb_pkg::ST_IDLE:
				if (in_acc) begin
					a_q <= seb_pkg::q40_t'($signed(s_tdata[31:0]));
					b_q <= seb_pkg::q40_t'($signed(s_tdata[63:32]));
					k_q <= seb_pkg::q40_t'($signed(s_tdata[31:0]));
				end
			seb_pkg::ST_K2:
				if (mul_done) begin
					k22_q  <= mul_r;
					y_q    <= '0;
					dy_q   <= seb_pkg::ONE_Q24;
					step_q <= '0;
				end
			seb_pkg::ST_STEP:
				if (mul_done) begin
					case (op_q)
						seb_pkg::OP_K1D: k1d_q <= seb_pkg::negsat(mul_r);
						seb_pkg::OP_Y2:  y2_q  <= seb_pkg::sat40(44'(y_q) + 44'(mul_r));
						seb_pkg::OP_D2:  d2_q  <= seb_pkg::sat40(44'(dy_q) + 44'(mul_r));
						seb_pkg::OP_K2D: k2d_q <= seb_pkg::negsat(mul_r);
						seb_pkg::OP_Y3:  y3_q  <= seb_pkg::sat40(44'(y_q) + 44'(mul_r));
						seb_pkg::OP_D3:  d3_q  <= seb_pkg::sat40(44'(dy_q) + 44'(mul_r));
						seb_pkg::OP_K3D: k3d_q <= seb_pkg::negsat(mul_r);
						seb_pkg::OP_Y4:  y4_q  <= seb_pkg::sat40(44'(y_q) + 44'(mul_r));
						seb_pkg::OP_D4:  d4_q  <= seb_pkg::sat40(44'(dy_q) + 44'(mul_r));
						seb_pkg::OP_K4D: k4d_q <= seb_pkg::negsat(mul_r);
						seb_pkg::OP_PY, seb_pkg::OP_PD: p_q <= mul_r;
						seb_pkg::OP_Y:   y_q   <= seb_pkg::sat40(44'(y_q) + 44'(mul_r));
						default: begin
							dy_q   <= seb_pkg::sat40(44'(dy_q) + 44'(mul_r));
							step_q <= step_q + 13'd1;
						end
					endcase
				end
			seb_pkg::ST_SHOT_END: begin
				case (phase_q)
					seb_pkg::PH_FA: begin
						fa_q <= y_q;
						k_q  <= b_q;
					end
					seb_pkg::PH_FB: fb_q <= y_q;
					default: ;
				endcase
			end
			seb_pkg::ST_CHECK_BRACKET: begin
				c_q      <= a_q;
				fc_q     <= fa_q;
				d_q      <= '0;
				mf_q     <= 1'b1;
				it_q     <= '0;
				res_k_q  <= '0;
				res_st_q <= seb_pkg::STAT_NOSIGN;
			end
			seb_pkg::ST_IT_BEGIN:
				if (!sec_ok) sv_q <= mid;
			seb_pkg::ST_SEC_DIV:
				if (div_done) sv_q <= sv_sec;
			seb_pkg::ST_CHOOSE: begin
				sv_q <= sv_new;
				k_q  <= sv_new;
				mf_q <= cn;
			end
			seb_pkg::ST_IT_UPD: begin
				d_q  <= c_q;
				c_q  <= b_q;
				fc_q <= fb_q;
				a_q  <= swap ? nb : na;
				b_q  <= swap ? na : nb;
				fa_q <= swap ? nfb : nfa;
				fb_q <= swap ? nfa : nfb;
			end
			seb_pkg::ST_IT_CHK: begin
				it_q     <= it_q + 8'd1;
				res_st_q <= conv ? seb_pkg::STAT_CONV : seb_pkg::STAT_LIMIT;
				// clamp b to the output width
				if (b_q > 40'sd2147483647) res_k_q <= 32'h7FFF_FFFF;
				else if (b_q < -40'sd2147483648) res_k_q <= 32'h8000_0000;
				else res_k_q <= b_q[31:0];
			end
			seb_pkg::ST_OUT:
				if (out_free) m_data_q <= {6'b0, res_st_q, res_k_q};
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == seb_pkg::ST_K2)
		else $error("accepted request did not start a shot");
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> mul_state && !mul_pend_q)
		else $error("multiplier request outside a multiply step");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3)
		else $error("invalid solve status on output");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == seb_pkg::ST_STEP |-> step_q < n_eff)
		else $error("step counter ran past the shot length");
endmodule

/* hw/rtl/seb_mul.sv */
// Shared 42x42 unsigned multiplier, one 21x21 partial product per cycle.
`timescale 1ns / 1ps
module seb_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  seb_pkg::mul_req_t req,
	output logic              done,
	output logic [83:0]       prod
);
	logic [41:0] a_q, b_q;
	logic [83:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q, done_q;
	logic [20:0] pa, pb;
	logic [41:0] part;
	logic [83:0] pp;

	always_comb begin
		pa   = cnt_q[0] ? a_q[41:21] : a_q[20:0];
		pb   = cnt_q[1] ? b_q[41:21] : b_q[20:0];
		part = 42'(pa) * 42'(pb);
		case (cnt_q)
			2'd0:    pp = {42'b0, part};
			2'd3:    pp = {part, 42'b0};
			default: pp = {21'b0, part, 21'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q)
		else $error("multiplier restarted while busy");
endmodule

/* hw/rtl/seb_div.sv */
// Restoring bit-serial divider, 80-bit numerator, quotient saturated at 2^41.
`timescale 1ns / 1ps
module seb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  seb_pkg::div_req_t req,
	output logic              done,
	output logic [41:0]       quo
);
	logic [79:0] n_q;
	logic [40:0] den_q, r_q, q_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q, sat_q;
	logic [41:0] rs;
	logic        ge;

	always_comb begin
		rs = {r_q, n_q[79]};
		ge = rs >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num;
			den_q <= req.den;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= {n_q[78:0], 1'b0};
			r_q <= ge ? 41'(rs - {1'b0, den_q}) : rs[40:0];
			q_q <= {q_q[39:0], ge};
			// quotient bits at 2^41 and above saturate
			if (ge && cnt_q <= 7'd38) sat_q <= 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? {1'b1, 41'b0} : {1'b0, q_q};

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
endmodule

/* tb/sv/shooting_eigenvalue_brent_rk4_unit_tb.sv */
// Testbench for the shooting eigenvalue solver: directed table, random brackets, predictor.
`timescale 1ns / 1ps
module shooting_eigenvalue_brent_rk4_unit_tb;

	// Register index past the end of the list; a write there must change nothing.
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int  RK_MAX_STEPS = 4096;
	localparam int  BRENT_ITERS  = 200;
	localparam longint LIM40_HI  = 64'sd549755813887;
	localparam longint LIM40_LO  = -64'sd549755813888;
	localparam longint UNIT_Q24  = 64'sd16777216;
	// Slowest request is two 4096-step shots, which run with no beat at all.
	localparam int  STALL_LIMIT  = 2500000;
	localparam int  RANDOM_ITEMS = 100;
	// Receiver stall long enough for the block to finish a request and back up.
	localparam int  LONG_HOLD    = 300000;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  reg_index;
		logic [24:0] reg_value;
		logic [31:0] k_low;
		logic [31:0] k_high;
		bit          typed;
		logic [31:0] typed_k;
		logic [1:0]  typed_status;
	} stim_row_t;

	typedef struct {
		logic [31:0] wavenumber;
		logic [1:0]  status;
	} eigen_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [31:0] bracket_low, [63:32] bracket_high
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] eigen_wavenumber, [33:32] solve_status, rest 0
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [24:0] cfg_data;

	// Predictor copy of the register file.
	longint      steps_reg;
	longint      h_reg;
	longint      tol_reg;

	eigen_result_t pending_roots[$];
	int          mismatch_count;
	int          idle_cycles;
	int          hold_request;
	stim_row_t   stim_table[$];

	shooting_eigenvalue_brent_rk4_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp40(longint v);
		if (v > LIM40_HI) return LIM40_HI;
		if (v < LIM40_LO) return LIM40_LO;
		return v;
	endfunction

	function automatic longint absl(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Fixed-point product, shifted right and truncated toward zero, then saturated.
	function automatic longint qmul(longint x, longint y, int sh);
		logic [127:0] p;
		longint r;
		p = 128'(absl(x)) * 128'(absl(y));
		p = p >> sh;
		r = longint'(p[63:0]);
		if ((x < 0) != (y < 0)) r = -r;
		return clamp40(r);
	endfunction

	// Integrate y'' = -k^2 y over n steps of size h; return y at the end of the shot.
	function automatic longint shot_end_position(longint k);
		longint k2, y, dy, n;
		longint k1d, y2, d2, k2d, y3, d3, k3d, y4, d4, k4d, sy, sd;
		k2 = qmul(k, k, 24);
		y = 0;
		dy = UNIT_Q24;
		n = (steps_reg > RK_MAX_STEPS) ? RK_MAX_STEPS : steps_reg;
		for (longint i = 0; i < n; i++) begin
			k1d = clamp40(-qmul(k2, y, 24));
			y2  = clamp40(y + qmul(dy, h_reg, 25));
			d2  = clamp40(dy + qmul(k1d, h_reg, 25));
			k2d = clamp40(-qmul(k2, y2, 24));
			y3  = clamp40(y + qmul(d2, h_reg, 25));
			d3  = clamp40(dy + qmul(k2d, h_reg, 25));
			k3d = clamp40(-qmul(k2, y3, 24));
			y4  = clamp40(y + qmul(d3, h_reg, 24));
			d4  = clamp40(dy + qmul(k3d, h_reg, 24));
			k4d = clamp40(-qmul(k2, y4, 24));
			sy  = clamp40(dy + 2 * (d2 + d3) + d4);
			sd  = clamp40(k1d + 2 * (k2d + k3d) + k4d);
			y   = clamp40(y + qmul(sy, h_reg, 24) / 6);
			dy  = clamp40(dy + qmul(sd, h_reg, 24) / 6);
		end
		return y;
	endfunction

	// Brent search for the wavenumber whose shot ends at y = 0 inside the bracket.
	function automatic eigen_result_t solve_wavenumber(logic [31:0] lo_bits,
			logic [31:0] hi_bits);
		eigen_result_t res;
		longint a, b, c, d, fa, fb, fc, fs, sv, q, tmp, qm;
		logic [127:0] num, quo;
		bit mf, between, neg, cn;
		logic [1:0] status;
		a = longint'($signed(lo_bits));
		b = longint'($signed(hi_bits));
		fa = shot_end_position(a);
		fb = shot_end_position(b);
		d = 0;
		mf = 1'b1;
		status = seb_pkg::STAT_LIMIT;
		if ((fa > 0 && fb > 0) || (fa < 0 && fb < 0)) begin
			res.wavenumber = '0;
			res.status = seb_pkg::STAT_NOSIGN;
			return res;
		end
		c = a;
		fc = fa;
		for (int it = 0; it < BRENT_ITERS; it++) begin
			if (absl(fb - fa) > tol_reg && absl(fb - fc) > tol_reg) begin
				num = 128'(absl(fb)) * 128'(absl(b - a));
				quo = num / 128'(absl(fb - fa));
				qm = (quo >= (128'd1 << 41)) ? (64'sd1 <<< 41) : longint'(quo[63:0]);
				neg = ((fb < 0) != ((b - a) < 0)) ? !((fb - fa) < 0) : ((fb - fa) < 0);
				sv = clamp40(b - (neg ? -qm : qm));
			end else begin
				sv = (a + b) / 2;
			end
			q = (3 * a + b) / 4;
			between = (sv > q && sv < b) || (sv < q && sv > b);
			cn = !between
				|| (mf && 2 * absl(sv - b) >= absl(b - c))
				|| (!mf && 2 * absl(sv - b) >= absl(c - d))
				|| (mf && absl(b - c) < tol_reg)
				|| (!mf && absl(c - d) < tol_reg);
			if (cn) begin
				sv = (a + b) / 2;
				mf = 1'b1;
			end else begin
				mf = 1'b0;
			end
			fs = shot_end_position(sv);
			d = c;
			c = b;
			fc = fb;
			if ((fa < 0 && fs > 0) || (fa > 0 && fs < 0)) begin
				b = sv;
				fb = fs;
			end else begin
				a = sv;
				fa = fs;
			end
			if (absl(fa) < absl(fb)) begin
				tmp = a; a = b; b = tmp;
				tmp = fa; fa = fb; fb = tmp;
			end
			if (absl(fb) < tol_reg || absl(b - a) < tol_reg) begin
				status = seb_pkg::STAT_CONV;
				break;
			end
		end
		if (b > 64'sd2147483647) b = 64'sd2147483647;
		if (b < -64'sd2147483648) b = -64'sd2147483648;
		res.wavenumber = b[31:0];
		res.status = status;
		return res;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Compare every result beat with the oldest pending root.
	always @(posedge clk) begin
		eigen_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_roots.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_roots.pop_front();
				if (m_tdata[31:0] !== want.wavenumber)
					report_mismatch("eigen_wavenumber", m_tdata[31:0], want.wavenumber);
				if (m_tdata[33:32] !== want.status)
					report_mismatch("solve_status", 32'(m_tdata[33:32]), 32'(want.status));
			end
		end
	end

	// Watchdog: count cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- drivers

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Result side: random stalls; a hold request keeps m_tready low until its count runs out.
	initial begin
		int hold_left;
		int gap;
		m_tready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 2) == 0) begin
				gap = gap_len();
				m_tready <= 1'b0;
				if (gap > 1) begin
					hold_left = gap - 1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hold until every pending root has come back, then let the block settle.
	task automatic wait_drained();
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [24:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			seb_pkg::CFG_SHOT_STEPS: steps_reg = longint'(value[12:0]);
			seb_pkg::CFG_STEP_SIZE:  h_reg     = longint'(value);
			seb_pkg::CFG_TOLERANCE:  tol_reg   = longint'(value);
			default: ;
		endcase
	endtask

	// Offer one bracket beat; s_tvalid stays high across back-to-back beats.
	task automatic send_bracket(logic [31:0] lo, logic [31:0] hi, bit typed,
			logic [31:0] tk, logic [1:0] ts);
		eigen_result_t want;
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hi, lo};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (typed) begin
			want.wavenumber = tk;
			want.status = ts;
		end else begin
			want = solve_wavenumber(lo, hi);
		end
		pending_roots.push_back(want);
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [24:0] value);
		stim_row_t r;
		r = '{ROW_CFG, idx, value, 32'd0, 32'd0, 1'b0, 32'd0, seb_pkg::STAT_CONV};
		stim_table.push_back(r);
	endtask

	task automatic add_req(logic [31:0] lo, logic [31:0] hi);
		stim_row_t r;
		r = '{ROW_REQ, seb_pkg::CFG_SHOT_STEPS, 25'd0, lo, hi, 1'b0, 32'd0,
			seb_pkg::STAT_CONV};
		stim_table.push_back(r);
	endtask

	task automatic add_typed(logic [31:0] lo, logic [31:0] hi, logic [31:0] k, logic [1:0] st);
		stim_row_t r;
		r = '{ROW_REQ, seb_pkg::CFG_SHOT_STEPS, 25'd0, lo, hi, 1'b1, k, st};
		stim_table.push_back(r);
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		logic [31:0] ka, kb, span;
		int steps;
		int phase_left;
		int sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = seb_pkg::CFG_SHOT_STEPS;
		cfg_data = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		hold_request = 0;
		steps_reg = 1000;
		h_reg = 16777;
		tol_reg = 17;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Step count above the cap saturates; k = 0 gives y(1) = 1 at both ends.
		add_cfg(seb_pkg::CFG_SHOT_STEPS, 25'd8191);
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'd4096);
		add_typed(32'd0, 32'd0, 32'd0, seb_pkg::STAT_NOSIGN);
		// Coarse shots from here on keep each request short.
		add_cfg(seb_pkg::CFG_SHOT_STEPS, 25'd2);
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'd8388608);
		add_cfg(seb_pkg::CFG_TOLERANCE, 25'd1024);
		add_typed(32'd0, 32'd0, 32'd0, seb_pkg::STAT_NOSIGN);
		add_req(32'd50331648, 32'd67108864);
		add_req(32'd67108864, 32'd50331648);
		add_req(32'h8000_0000, 32'h7FFF_FFFF);
		add_req(32'h7FFF_FFFF, 32'h8000_0000);
		add_req(32'h8000_0000, 32'h8000_0000);
		add_req(32'hFD00_0000, 32'hFC00_0000);
		// Zero step size: every shot ends at zero, which counts as a sign change.
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'd0);
		add_req(32'd16777216, 32'd83886080);
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'd8388608);
		// Zero steps behave the same way.
		add_cfg(seb_pkg::CFG_SHOT_STEPS, 25'd0);
		add_req(32'd16777216, 32'd83886080);
		// Zero tolerance never converges: runs into the iteration limit.
		add_cfg(seb_pkg::CFG_SHOT_STEPS, 25'd1);
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'd16777216);
		add_cfg(seb_pkg::CFG_TOLERANCE, 25'd0);
		add_req(32'd16777216, 32'd50331648);
		add_cfg(seb_pkg::CFG_TOLERANCE, 25'd16777216);
		add_req(32'd16777216, 32'd50331648);
		add_cfg(CFG_UNUSED, 25'h1AAAAAA);
		add_req(32'd33554432, 32'd67108864);
		add_cfg(seb_pkg::CFG_TOLERANCE, 25'h1FFFFFF);
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'h1FFFFFF);
		add_req(32'h5555_5555, 32'hAAAA_AAAA);
		add_cfg(seb_pkg::CFG_SHOT_STEPS, 25'h1FF0003);
		add_cfg(seb_pkg::CFG_STEP_SIZE, 25'd5592405);
		add_cfg(seb_pkg::CFG_TOLERANCE, 25'd17);
		add_req(32'd33554432, 32'd67108864);

		// Walk the table; register writes happen only with nothing in flight.
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				s_tvalid <= 1'b0;
				wait_drained();
				write_reg(stim_table[i].reg_index, stim_table[i].reg_value);
			end else begin
				send_bracket(stim_table[i].k_low, stim_table[i].k_high, stim_table[i].typed,
					stim_table[i].typed_k, stim_table[i].typed_status);
			end
		end

		// Random phases: fresh registers, then a burst of brackets.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			s_tvalid <= 1'b0;
			wait_drained();
			steps = $urandom_range(1, 6);
			write_reg(seb_pkg::CFG_SHOT_STEPS, 25'(steps));
			write_reg(seb_pkg::CFG_STEP_SIZE,
				25'(16777216 / steps + $urandom_range(0, 64) - 32));
			case ($urandom_range(0, 3))
				0: write_reg(seb_pkg::CFG_TOLERANCE, 25'($urandom_range(1, 64)));
				1: write_reg(seb_pkg::CFG_TOLERANCE, 25'($urandom_range(1024, 65536)));
				2: write_reg(seb_pkg::CFG_TOLERANCE, 25'($urandom_range(65536, 16777216)));
				default: write_reg(seb_pkg::CFG_TOLERANCE, 25'($urandom));
			endcase
			phase_left = $urandom_range(5, 15);
			while (phase_left > 0 && sent < RANDOM_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					ka = $urandom;
					kb = $urandom;
				end else begin
					ka = $urandom_range(0, 32'd167772160);
					span = $urandom_range(32'd4194304, 32'd50331648);
					kb = ka + span;
					if ($urandom_range(0, 1)) begin
						ka = -ka;
						kb = -kb;
					end
					if ($urandom_range(0, 3) == 0) {ka, kb} = {kb, ka};
				end
				// Long receiver stall while brackets keep coming: the block backs up.
				if (sent == 10) hold_request = LONG_HOLD;
				// Sender pause: hold off until every pending root is back.
				if (sent == 40) begin
					s_tvalid <= 1'b0;
					wait_drained();
				end
				send_bracket(ka, kb, 1'b0, 32'd0, seb_pkg::STAT_CONV);
				sent++;
				phase_left--;
			end
		end
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && pending_roots.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
